FILE: rtl/krh_pkg.sv
package krh_pkg;

   // Field widths of the fingerprint datapath.
   localparam int HASH_W = 61;
   localparam int LEN_W  = 32;

   // The 61 by 61 product is built from 32-bit slices of each operand.
   localparam int HALF_W = 32;
   localparam int HI_W   = HASH_W - HALF_W;
   localparam int PROD_W = 2 * HASH_W;

   // Mersenne prime 2^61 - 1.
   localparam logic [HASH_W-1:0] PRIME = {HASH_W{1'b1}};

   // Operation carried in the opcode field of an input beat.
   typedef enum logic {
      OP_CONCAT = 1'b0,
      OP_STRIP  = 1'b1
   } op_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] op_a;
      logic [HASH_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] product;
   } mul_rsp_type;

   // The all-ones word is the prime itself and stands for zero.
   function automatic logic [HASH_W-1:0] map_prime(input logic [HASH_W-1:0] value);
      return (value == PRIME) ? {HASH_W{1'b0}} : value;
   endfunction

endpackage

FILE: rtl/krh_mulmod.sv
module krh_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  krh_pkg::mul_req_type mul_req,
   output krh_pkg::mul_rsp_type mul_rsp
);

   localparam logic [2:0] FOLD_STEP = 3'd4;

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [2:0]                   cnt_ff, cnt_in;
   logic [krh_pkg::HASH_W-1:0]   a_ff, a_in;
   logic [krh_pkg::HASH_W-1:0]   b_ff, b_in;
   logic [krh_pkg::PROD_W-1:0]   acc_ff, acc_in;
   logic [krh_pkg::HASH_W-1:0]   prod_ff, prod_in;

   logic [krh_pkg::HALF_W-1:0]   slice_a;
   logic [krh_pkg::HALF_W-1:0]   slice_b;
   logic [2*krh_pkg::HALF_W-1:0] partial;
   logic [krh_pkg::PROD_W-1:0]   partial_ext;
   logic [krh_pkg::PROD_W-1:0]   partial_sh;
   logic [krh_pkg::HASH_W:0]     fold_one;
   logic [krh_pkg::HASH_W:0]     fold_two;

   // Count bit 1 picks the upper slice of a, bit 0 that of b.
   assign slice_a = cnt_ff[1]
      ? {{(krh_pkg::HALF_W - krh_pkg::HI_W){1'b0}}, a_ff[krh_pkg::HASH_W-1:krh_pkg::HALF_W]}
      : a_ff[krh_pkg::HALF_W-1:0];
   assign slice_b = cnt_ff[0]
      ? {{(krh_pkg::HALF_W - krh_pkg::HI_W){1'b0}}, b_ff[krh_pkg::HASH_W-1:krh_pkg::HALF_W]}
      : b_ff[krh_pkg::HALF_W-1:0];
   assign partial     = slice_a * slice_b;
   assign partial_ext = {{(krh_pkg::PROD_W - 2*krh_pkg::HALF_W){1'b0}}, partial};

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    partial_sh = partial_ext;
         2'd3:    partial_sh = partial_ext << (2*krh_pkg::HALF_W);
         default: partial_sh = partial_ext << krh_pkg::HALF_W;
      endcase
   end

   // Two Mersenne folds bring the product below 2^61.
   assign fold_one = {1'b0, acc_ff[krh_pkg::HASH_W-1:0]}
                   + {1'b0, acc_ff[krh_pkg::PROD_W-1:krh_pkg::HASH_W]};
   assign fold_two = {1'b0, fold_one[krh_pkg::HASH_W-1:0]}
                   + {{krh_pkg::HASH_W{1'b0}}, fold_one[krh_pkg::HASH_W]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (mul_req.start) begin
         run_in = 1'b1;
         cnt_in = 3'd0;
         a_in   = mul_req.op_a;
         b_in   = mul_req.op_b;
         acc_in = {krh_pkg::PROD_W{1'b0}};
      end else if (run_ff) begin
         if (cnt_ff == FOLD_STEP) begin
            prod_in = krh_pkg::map_prime(fold_two[krh_pkg::HASH_W-1:0]);
            done_in = 1'b1;
            run_in  = 1'b0;
         end else begin
            acc_in = acc_ff + partial_sh;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

endmodule

FILE: rtl/karp_rabin_hash_combine_unit.sv
// Karp-Rabin fingerprint combiner modulo 2^61 - 1. Software writes the base
// through csr_wr_en and csr_wr_data while the unit is idle. An input beat is
// taken when start is high and busy is low; the unit then stays busy and
// computes base^shift_len by square-and-multiply on one shared modular
// multiplier, which builds each product from four 32 by 32 slices and folds
// it. From acceptance to the result strobe an item takes one squaring per
// exponent bit up to the highest set bit, one more multiply for each set
// bit and a final multiply and combine. The result beat is on rsp_valid and
// rsp_result_hash for exactly one cycle and cannot be held off, so the
// receiver must take it when it appears; busy is already low in that cycle,
// so the next item may be started alongside it.
module karp_rabin_hash_combine_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [krh_pkg::HASH_W-1:0] req_first_hash,
   input  logic [krh_pkg::HASH_W-1:0] req_second_hash,
   input  logic [krh_pkg::LEN_W-1:0]  req_shift_len,
   output logic                       rsp_valid,
   output logic [krh_pkg::HASH_W-1:0] rsp_result_hash,
   input  logic                       csr_wr_en,
   input  logic [krh_pkg::HASH_W-1:0] csr_wr_data
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STEP = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_COMB = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [krh_pkg::HASH_W-1:0] base_ff, base_in;
   logic                       op_ff, op_in;
   logic [krh_pkg::HASH_W-1:0] h1_ff, h1_in;
   logic [krh_pkg::HASH_W-1:0] h2_ff, h2_in;
   logic [krh_pkg::LEN_W-1:0]  exp_ff, exp_in;
   logic [krh_pkg::HASH_W-1:0] acc_ff, acc_in;
   logic [krh_pkg::HASH_W-1:0] sq_ff, sq_in;
   logic [krh_pkg::HASH_W-1:0] rsp_hash_ff, rsp_hash_in;

   krh_pkg::mul_req_type mul_req;
   krh_pkg::mul_rsp_type mul_rsp;

   logic [krh_pkg::HASH_W:0]   cat_sum;
   logic [krh_pkg::HASH_W:0]   cat_one;
   logic [krh_pkg::HASH_W:0]   cat_two;
   logic [krh_pkg::HASH_W-1:0] cat_res;
   logic                       sub_borrow;
   logic [krh_pkg::HASH_W-1:0] sub_res;

   krh_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Final combine. In the combine state acc_ff holds the product of the
   // selected hash and the power. Concatenation adds the right hash and folds
   // twice; stripping a prefix subtracts and adds the prime back on borrow,
   // which in 61-bit arithmetic lands on the correct residue.
   assign cat_sum = {1'b0, acc_ff} + {1'b0, h2_ff};
   assign cat_one = {1'b0, cat_sum[krh_pkg::HASH_W-1:0]}
                  + {{krh_pkg::HASH_W{1'b0}}, cat_sum[krh_pkg::HASH_W]};
   assign cat_two = {1'b0, cat_one[krh_pkg::HASH_W-1:0]}
                  + {{krh_pkg::HASH_W{1'b0}}, cat_one[krh_pkg::HASH_W]};
   assign cat_res = krh_pkg::map_prime(cat_two[krh_pkg::HASH_W-1:0]);

   assign sub_borrow = (h1_ff < acc_ff);
   assign sub_res    = h1_ff - acc_ff + (sub_borrow ? krh_pkg::PRIME : {krh_pkg::HASH_W{1'b0}});

   // The exponent register is shifted right once per squaring, so the loop
   // ends as soon as no set bit remains rather than after every length bit.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      base_in      = csr_wr_en ? csr_wr_data : base_ff;
      op_in        = op_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_hash_in  = rsp_hash_ff;
      mul_req.start = 1'b0;
      mul_req.op_a  = sq_ff;
      mul_req.op_b  = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               h1_in    = krh_pkg::map_prime(req_first_hash);
               h2_in    = krh_pkg::map_prime(req_second_hash);
               exp_in   = req_shift_len;
               acc_in   = {{(krh_pkg::HASH_W-1){1'b0}}, 1'b1};
               sq_in    = krh_pkg::map_prime(base_ff);
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            mul_req.start = 1'b1;
            if (exp_ff == {krh_pkg::LEN_W{1'b0}}) begin
               // The power is complete: multiply it into the selected hash.
               mul_req.op_a = (op_ff == krh_pkg::OP_CONCAT) ? h1_ff : h2_ff;
               mul_req.op_b = acc_ff;
               state_in     = ST_FIN;
            end else if (exp_ff[0]) begin
               mul_req.op_a = acc_ff;
               state_in     = ST_ACC;
            end else begin
               state_in = ST_SQR;
            end
         end
         ST_ACC: begin
            if (mul_rsp.done) begin
               acc_in        = mul_rsp.product;
               mul_req.start = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               exp_in   = exp_ff >> 1;
               state_in = ST_STEP;
            end
         end
         ST_FIN: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.product;
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            rsp_hash_in  = (op_ff == krh_pkg::OP_CONCAT) ? cat_res : sub_res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= {krh_pkg::HASH_W{1'b0}};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_hash = rsp_hash_ff;

   // A result beat only ever follows the combine state.
   a_rsp_after_comb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_COMB))
      else $error("result beat without a preceding combine");

   // Results are always fully reduced.
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_hash != krh_pkg::PRIME))
      else $error("result equals the prime");

   // An accepted beat starts the exponent loop on the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_STEP))
      else $error("accepted beat did not start the sequencer");

   // The multiplier only answers while the sequencer waits for it.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_ACC || state_ff == ST_SQR || state_ff == ST_FIN))
      else $error("unexpected product from the multiplier");

endmodule

FILE: test/tb_karp_rabin_hash_combine_unit.sv
`timescale 1ns / 1ps

module tb_karp_rabin_hash_combine_unit;

   localparam int H = krh_pkg::HASH_W;

   typedef logic [krh_pkg::HASH_W-1:0] hash_type;
   typedef logic [krh_pkg::LEN_W-1:0]  len_type;

   // One row of the directed table. Where the answer can be worked out by
   // hand, known is set and the answer is typed in; otherwise the fingerprint
   // predictor supplies the expectation.
   typedef struct packed {
      hash_type        base;
      krh_pkg::op_type op;
      hash_type        first;
      hash_type        second;
      len_type         len;
      logic            known;
      hash_type        answer;
   } dir_row_type;

   localparam hash_type P         = krh_pkg::PRIME;
   localparam int    STALL_LIMIT  = 4000;
   localparam int    DRAIN_CYCLES = 40;
   localparam int    PHASE_ITEMS  = 250;
   localparam int    NUM_PHASES   = 5;
   localparam int    NUM_DIRECTED = 24;

   // The directed part walks from the reset base (zero) through the unit
   // base, the base equal to minus one, a base equal to p (which must act as
   // zero), the base two (powers that wrap across 2^61) and an arbitrary base.
   localparam dir_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{0,   krh_pkg::OP_CONCAT, 0,     0,     0,             1'b1, 0},
      '{0,   krh_pkg::OP_CONCAT, P-1,   1,     0,             1'b1, 0},
      '{0,   krh_pkg::OP_CONCAT, P-1,   P-1,   0,             1'b1, P-2},
      '{0,   krh_pkg::OP_CONCAT, 5,     7,     1,             1'b1, 7},
      '{0,   krh_pkg::OP_STRIP,  5,     7,     0,             1'b1, P-2},
      '{0,   krh_pkg::OP_STRIP,  9,     4,     32'hFFFF_FFFF, 1'b1, 9},
      '{0,   krh_pkg::OP_CONCAT, P,     P,     3,             1'b1, 0},
      '{0,   krh_pkg::OP_STRIP,  P,     3,     0,             1'b1, P-3},
      '{0,   krh_pkg::OP_CONCAT, 12345, P,     0,             1'b1, 12345},
      '{1,   krh_pkg::OP_CONCAT, 100,   23,    32'hFFFF_FFFF, 1'b1, 123},
      '{1,   krh_pkg::OP_STRIP,  0,     1,     7,             1'b1, P-1},
      '{1,   krh_pkg::OP_STRIP,  P-1,   P-1,   1,             1'b1, 0},
      '{P-1, krh_pkg::OP_CONCAT, 3,     10,    1,             1'b1, 7},
      '{P-1, krh_pkg::OP_CONCAT, 3,     10,    2,             1'b1, 13},
      '{P-1, krh_pkg::OP_STRIP,  1,     1,     32'hFFFF_FFFF, 1'b1, 2},
      '{P-1, krh_pkg::OP_STRIP,  P-1,   2,     32'h8000_0000, 1'b1, P-3},
      '{P,   krh_pkg::OP_CONCAT, 4,     6,     5,             1'b1, 6},
      '{P,   krh_pkg::OP_CONCAT, 4,     6,     0,             1'b1, 10},
      '{2,   krh_pkg::OP_CONCAT, 1,     0,     60,            1'b1, 61'h1000_0000_0000_0000},
      '{2,   krh_pkg::OP_CONCAT, 1,     0,     61,            1'b1, 1},
      '{2,   krh_pkg::OP_STRIP,  61'h0F0F_0F0F_0F0F_0F0F, 61'h1234_5678_9ABC_DEF0,
                                 32'hFFFF_FFFF, 1'b0, 0},
      '{2,   krh_pkg::OP_CONCAT, P-1,   P-1,   32'hAAAA_AAAA, 1'b0, 0},
      '{61'h0123_4567_89AB_CDEF, krh_pkg::OP_CONCAT, P-1, P-1, 32'hFFFF_FFFF, 1'b0, 0},
      '{61'h0123_4567_89AB_CDEF, krh_pkg::OP_STRIP,  0,   P-1, 32'h1234_5678, 1'b0, 0}
   };

   // Every input is held at a known value from time zero.
   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     start           = 1'b0;
   logic     busy;
   logic     req_opcode      = 1'b0;
   hash_type req_first_hash  = '0;
   hash_type req_second_hash = '0;
   len_type  req_shift_len   = '0;
   logic     rsp_valid;
   hash_type rsp_result_hash;
   logic     csr_wr_en       = 1'b0;
   hash_type csr_wr_data     = '0;

   // Shadow of the base register and the queue of fingerprints still owed.
   hash_type base_shadow = '0;
   hash_type pending_hashes [$];
   hash_type owed_hash;
   int    error_count   = 0;
   int    beats_sent    = 0;
   int    results_seen  = 0;
   int    bases_written = 0;
   int    drain_pauses  = 0;
   int    quiet_cycles  = 0;
   bit    idling_on     = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   karp_rabin_hash_combine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_first_hash  (req_first_hash),
      .req_second_hash (req_second_hash),
      .req_shift_len   (req_shift_len),
      .rsp_valid       (rsp_valid),
      .rsp_result_hash (rsp_result_hash),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Fingerprint predictor, arithmetic modulo p = 2^61 - 1.
   // ---------------------------------------------------------------------

   // Two Mersenne folds bring any 64-bit value below 2^61; the prime itself
   // is then mapped to zero, so the value returned is always below p.
   function automatic hash_type mersenne_fold(input logic [63:0] value);
      logic [63:0] sum;
      sum = {3'b000, value[H-1:0]} + (value >> H);
      sum = {3'b000, sum[H-1:0]} + (sum >> H);
      return (sum[H-1:0] == P) ? '0 : sum[H-1:0];
   endfunction

   // Full 122-bit product, then the high half is folded onto the low half.
   function automatic hash_type mersenne_mul(input hash_type a, input hash_type b);
      logic [2*H-1:0] product;
      product = a * b;
      return mersenne_fold(64'(product[H-1:0]) + 64'(product[2*H-1:H]));
   endfunction

   // Square-and-multiply from the least significant exponent bit upwards.
   // A zero exponent gives one whatever the base, even a zero base.
   function automatic hash_type base_power(input hash_type base, input len_type exponent);
      hash_type square;
      hash_type power;
      square = mersenne_fold(64'(base));
      power  = hash_type'(1);
      for (int i = 0; i < krh_pkg::LEN_W; i++) begin
         if (exponent[i]) begin
            power = mersenne_mul(power, square);
         end
         square = mersenne_mul(square, square);
      end
      return power;
   endfunction

   // Concatenation shifts the left hash by base^len and adds the right hash;
   // stripping removes the shifted prefix hash, wrapping through p when the
   // difference would go negative. Both hashes are reduced first, so an
   // all-ones hash behaves as zero.
   function automatic hash_type combined_hash(input krh_pkg::op_type op,
                                              input hash_type first,
                                              input hash_type second,
                                              input len_type len);
      hash_type left;
      hash_type right;
      hash_type scaled;
      left  = mersenne_fold(64'(first));
      right = mersenne_fold(64'(second));
      if (op == krh_pkg::OP_CONCAT) begin
         scaled = mersenne_mul(left, base_power(base_shadow, len));
         return mersenne_fold(64'(scaled) + 64'(right));
      end
      scaled = mersenne_mul(right, base_power(base_shadow, len));
      // The sum below may overflow 61 bits, but the true difference is
      // below p, so the wrapped result is exact.
      return (left >= scaled) ? left - scaled : left + P - scaled;
   endfunction

   // ---------------------------------------------------------------------
   // Random field values, weighted towards the corners of each range.
   // ---------------------------------------------------------------------

   function automatic hash_type random_hash();
      logic [63:0] raw;
      int unsigned pick;
      raw  = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 6) begin
         return '0;
      end else if (pick < 12) begin
         return P - 1;
      end else if (pick < 16) begin
         return P;
      end
      return raw[H-1:0];
   endfunction

   function automatic len_type random_len();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return '0;
      end else if (pick < 40) begin
         return len_type'($urandom_range(63));
      end else if (pick < 50) begin
         return '1;
      end else if (pick < 60) begin
         return len_type'(1) << $urandom_range(krh_pkg::LEN_W - 1);
      end
      return len_type'($urandom());
   endfunction

   // ---------------------------------------------------------------------
   // Sender side.
   // ---------------------------------------------------------------------

   // Presents one beat and holds it until the unit takes it, dropping start
   // with a chance of 36 in a hundred while idling is switched on. Start is
   // assigned exactly once per clock edge, so a beat that follows straight
   // after an accepted one never sees start lowered and raised in one step.
   task automatic issue_beat(input krh_pkg::op_type op, input hash_type first,
                             input hash_type second, input len_type len,
                             input hash_type want);
      req_opcode      <= op;
      req_first_hash  <= first;
      req_second_hash <= second;
      req_shift_len   <= len;
      do begin
         start <= !(idling_on && ($urandom_range(99) < 36));
         @(posedge clock);
      end while (!(start && !busy));
      pending_hashes.push_back(want);
      beats_sent++;
   endtask

   // Holds the sender off until every owed fingerprint has come back. Each
   // beat yields exactly one result, so once the queue is empty the unit is
   // idle.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_hashes.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // The base register is only written with the unit idle.
   task automatic write_base(input hash_type value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_shadow = value;
      bases_written++;
   endtask

   // ---------------------------------------------------------------------
   // Result checker. The result beat lasts exactly one cycle and cannot be
   // held off, so it is taken at the edge that ends that cycle. Outputs are
   // read before the unit's own updates at this edge take effect.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_hashes.size() == 0) begin
            error_count++;
            $display("%0t: result beat with none expected, expected nothing, got %h",
                     $time, rsp_result_hash);
         end else begin
            owed_hash = pending_hashes.pop_front();
            if (rsp_result_hash !== owed_hash) begin
               error_count++;
               $display("%0t: result_hash mismatch, expected %h, got %h",
                        $time, owed_hash, rsp_result_hash);
            end
         end
      end
   end

   // Watchdog: a long run of cycles with neither an input nor a result beat
   // means the unit is stuck.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------

   initial begin
      dir_row_type     row;
      krh_pkg::op_type op;
      hash_type        first;
      hash_type        second;
      len_type         len;
      hash_type        phase_base;
      int              directed_count;

      directed_count = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the opening rows rely on the base being zero after
      // reset; later rows rewrite the base whenever the table changes it.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.base != base_shadow) begin
            write_base(row.base);
         end
         issue_beat(row.op, row.first, row.second, row.len,
                    row.known ? row.answer
                              : combined_hash(row.op, row.first, row.second, row.len));
         directed_count++;
      end

      // Random part in phases, each with a base of its own. The middle phase
      // runs with no idling at all, so beats follow back to back.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            1:       phase_base = P - 1;
            3:       phase_base = '0;
            default: phase_base = hash_type'({$urandom(), $urandom()});
         endcase
         write_base(phase_base);
         idling_on = (phase != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op     = krh_pkg::op_type'($urandom_range(1));
            first  = random_hash();
            second = random_hash();
            len    = random_len();
            // Now and then the sender waits for the unit to run dry.
            if ($urandom_range(99) < 2) begin
               wait_for_drain();
               drain_pauses++;
            end
            issue_beat(op, first, second, len, combined_hash(op, first, second, len));
         end
      end

      // Let the last results arrive, then allow a little longer so that any
      // stray extra result beat would still be caught.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_hashes.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived, expected 0 left, got %0d",
                  $time, pending_hashes.size(), pending_hashes.size());
      end

      $display("Combined %0d fingerprints (%0d directed, %0d random) under %0d base writes.",
               beats_sent, directed_count, beats_sent - directed_count, bases_written);
      $display("Checked %0d result beats, %0d mid-run drains, %0d mismatches.",
               results_seen, drain_pauses, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
